// File: src/srq_pkg.sv
// ----------------------------------------------------------------------------
// srq_pkg: shared types and constants for the sound request queue player
// Holds the operation and output kind codes, field widths, default parameter
// values, and the structs passed between the player and the request ring.
// ----------------------------------------------------------------------------
package srq_pkg;

	// Fixed field widths of the input and result words.
	localparam int OP_W      = 2;
	localparam int SID_W     = 4;
	localparam int ENTRY_W   = 24;
	localparam int SIL_W     = 8;
	localparam int KIND_W    = 2;

	// Default values for the top-level parameters.
	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_SOUND_COUNT = 16;
	localparam int DEF_ADDR_WIDTH  = 24;

	// Operation carried by each input word.
	typedef enum logic [OP_W-1:0] {
		OP_PLAY  = 2'd0,
		OP_FETCH = 2'd1,
		OP_LOAD  = 2'd2
	} op_t;

	// What a result word carries.
	typedef enum logic [KIND_W-1:0] {
		KIND_NONE    = 2'd0,
		KIND_SAMPLE  = 2'd1,
		KIND_SILENCE = 2'd2
	} kind_t;

	// Requests from the player to the ring.
	typedef struct packed {
		logic push;
		logic pop;
	} ring_ctl_t;

	// Ring status seen by the player.
	typedef struct packed {
		logic             empty;
		logic             full;
		logic [SID_W-1:0] head_sound;
	} ring_stat_t;

endpackage

// File: src/srq_ring.sv
// ----------------------------------------------------------------------------
// srq_ring: circular queue of requested sound numbers
// One slot always stays free, so full means the tail sits just behind the
// head. The oldest entry is offered to the player at all times.
// ----------------------------------------------------------------------------
module srq_ring import srq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ring_ctl_t        ctl,
	input  logic [SID_W-1:0] push_sound,
	output ring_stat_t       stat
);

	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [QW-1:0] LAST_IDX = QW'(QUEUE_DEPTH - 1);

	logic [SID_W-1:0] slots_q [QUEUE_DEPTH];
	logic [QW-1:0]    head_q;
	logic [QW-1:0]    tail_q;
	logic [QW-1:0]    head_next;
	logic [QW-1:0]    tail_next;

	assign head_next = (head_q == LAST_IDX) ? '0 : head_q + QW'(1);
	assign tail_next = (tail_q == LAST_IDX) ? '0 : tail_q + QW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (ctl.push) begin
				tail_q <= tail_next;
			end
			if (ctl.pop) begin
				head_q <= head_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			slots_q[tail_q] <= push_sound;
		end
	end

	assign stat.empty      = (head_q == tail_q);
	assign stat.full       = (tail_next == head_q);
	assign stat.head_sound = slots_q[head_q];

endmodule

// File: src/srq_table.sv
// ----------------------------------------------------------------------------
// srq_table: per-sound base address and length table
// Loaded one entry per load word; read at the sound at the head of the ring.
// ----------------------------------------------------------------------------
module srq_table import srq_pkg::*; #(
	parameter int SOUND_COUNT = DEF_SOUND_COUNT,
	parameter int ADDR_WIDTH  = DEF_ADDR_WIDTH
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [SID_W-1:0]      wr_sound,
	input  logic [ADDR_WIDTH-1:0] wr_base,
	input  logic [ADDR_WIDTH-1:0] wr_len,
	input  logic [SID_W-1:0]      rd_sound,
	output logic [ADDR_WIDTH-1:0] rd_base,
	output logic [ADDR_WIDTH-1:0] rd_len
);

	localparam int SW = (SOUND_COUNT > 1) ? $clog2(SOUND_COUNT) : 1;

	logic [ADDR_WIDTH-1:0] base_q [SOUND_COUNT];
	logic [ADDR_WIDTH-1:0] len_q  [SOUND_COUNT];
	logic [SW-1:0]         wr_idx;
	logic [SW-1:0]         rd_idx;

	// Callers only present sound numbers below the table size.
	assign wr_idx = SW'(wr_sound);
	assign rd_idx = SW'(rd_sound);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			base_q[wr_idx] <= wr_base;
			len_q[wr_idx]  <= wr_len;
		end
	end

	assign rd_base = base_q[rd_idx];
	assign rd_len  = len_q[rd_idx];

endmodule

// File: src/srq_player.sv
// ----------------------------------------------------------------------------
// srq_player: request decode and active sound tracking
// Decodes the word leaving the input stage, drives the ring and the table,
// keeps the playing sound's base, length and position, and forms the result.
// ----------------------------------------------------------------------------
module srq_player import srq_pkg::*; #(
	parameter int SOUND_COUNT = DEF_SOUND_COUNT,
	parameter int ADDR_WIDTH  = DEF_ADDR_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [OP_W-1:0]       op,
	input  logic [SID_W-1:0]      sound_num,
	input  logic [SIL_W-1:0]      silence,
	input  ring_stat_t            ring_stat,
	input  logic [ADDR_WIDTH-1:0] tbl_base,
	input  logic [ADDR_WIDTH-1:0] tbl_len,
	output ring_ctl_t             ring_ctl,
	output logic                  tbl_wr_en,
	output logic                  res_accepted,
	output kind_t                 res_kind,
	output logic [ADDR_WIDTH-1:0] res_addr,
	output logic [SIL_W-1:0]      res_silence,
	output logic [SID_W-1:0]      res_sound
);

	logic                  active_q;
	logic [SID_W-1:0]      sound_q;
	logic [ADDR_WIDTH-1:0] base_q;
	logic [ADDR_WIDTH-1:0] len_q;
	logic [ADDR_WIDTH-1:0] pos_q;

	logic                  sid_ok;
	logic                  play_ok;
	logic                  take_active;
	logic [ADDR_WIDTH-1:0] cur_base;
	logic [ADDR_WIDTH-1:0] cur_len;
	logic [ADDR_WIDTH-1:0] cur_pos;
	logic [SID_W-1:0]      cur_sound;
	logic [ADDR_WIDTH-1:0] pos_next;
	logic                  sound_done;
	logic                  step;

	assign sid_ok  = ({{(32 - SID_W){1'b0}}, sound_num} < 32'(SOUND_COUNT));
	assign play_ok = sid_ok && !ring_stat.full;

	// A sound already running keeps going; otherwise the head request starts.
	assign take_active = active_q || !ring_stat.empty;
	assign cur_base    = active_q ? base_q  : tbl_base;
	assign cur_len     = active_q ? len_q   : tbl_len;
	assign cur_pos     = active_q ? pos_q   : '0;
	assign cur_sound   = active_q ? sound_q : ring_stat.head_sound;
	assign pos_next    = cur_pos + ADDR_WIDTH'(1);
	assign sound_done  = (pos_next >= cur_len) || (pos_next == '0);

	assign step          = fire && (op == OP_FETCH) && take_active;
	assign ring_ctl.push = fire && (op == OP_PLAY) && play_ok;
	assign ring_ctl.pop  = fire && (op == OP_FETCH) && !active_q && !ring_stat.empty;
	assign tbl_wr_en     = fire && (op == OP_LOAD) && sid_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			sound_q  <= '0;
			base_q   <= '0;
			len_q    <= '0;
			pos_q    <= '0;
		end else if (step) begin
			sound_q <= cur_sound;
			if (sound_done) begin
				active_q <= 1'b0;
				base_q   <= '0;
				len_q    <= '0;
				pos_q    <= '0;
			end else begin
				active_q <= 1'b1;
				base_q   <= cur_base;
				len_q    <= cur_len;
				pos_q    <= pos_next;
			end
		end
	end

	always_comb begin
		res_accepted = 1'b0;
		res_kind     = KIND_NONE;
		res_addr     = '0;
		res_silence  = '0;
		res_sound    = '0;
		case (op)
			OP_PLAY: begin
				res_accepted = play_ok;
			end
			OP_FETCH: begin
				res_accepted = 1'b1;
				if (take_active) begin
					res_kind  = KIND_SAMPLE;
					res_addr  = cur_base + cur_pos;
					res_sound = cur_sound;
				end else begin
					res_kind    = KIND_SILENCE;
					res_silence = silence;
				end
			end
			OP_LOAD: begin
				res_accepted = sid_ok;
			end
			default: begin
				res_accepted = 1'b0;
			end
		endcase
	end

endmodule

// File: src/sound_request_queue_player.sv
// ----------------------------------------------------------------------------
// sound_request_queue_player: queued sound requests feeding a sample player
// Queues play requests in a ring, looks up each sound's sample range in a
// table, and turns each fetch word into one sample address or silence byte.
// ----------------------------------------------------------------------------
// Usage:
// Input words arrive on the s_ stream. s_tuser carries the operation: play
// (queue a sound number), fetch (produce one output byte), or load (write a
// sound's base address and length into the table). Every input word yields
// exactly one result word on the m_ stream, in order.
// A fetch pops the oldest request when nothing is playing, then reports the
// address of the current sample byte and advances; the sound ends when its
// position reaches its length. With nothing queued, the fetch reports the
// silence byte set through the cfg_ write port.
// A word accepted on s_ is registered in the input stage, processed by one
// level of logic, and its result word is registered in the result stage and
// offered on m_. Throughput is one word per cycle while the receiver takes
// results, set by the single pass through the ring head, the table lookup and the address adder.
// When the receiver stalls, the result register holds and the input stage
// fills; s_tready drops only when both are occupied.
// Reset empties the queue, stops any playing sound and sets silence to 0.
// The sound table and ring slots are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sound_request_queue_player import srq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int SOUND_COUNT = DEF_SOUND_COUNT,
	parameter int ADDR_WIDTH  = DEF_ADDR_WIDTH
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	// Silence byte register write port.
	input  logic                                       cfg_wr_en,
	input  logic [SIL_W-1:0]                           cfg_wr_data,
	// Input stream.
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// s_tdata: sound number [3:0], entry_base [27:4], entry_length [51:28], zeros.
	input  logic [((SID_W + 2 * ENTRY_W + 7) / 8) * 8-1:0] s_tdata,
	// s_tuser: op [1:0].
	input  logic [OP_W-1:0]                            s_tuser,
	// Result stream.
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// m_tdata: accepted, sample_address, silence_byte, playing_sound, zeros.
	output logic [((1 + ADDR_WIDTH + SIL_W + SID_W + 7) / 8) * 8-1:0] m_tdata,
	// m_tuser: output_kind [1:0].
	output logic [KIND_W-1:0]                          m_tuser
);

	localparam int OUT_USED_W = 1 + ADDR_WIDTH + SIL_W + SID_W;
	localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

	// Silence byte register.
	logic [SIL_W-1:0] silence_q;

	// Input stage.
	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [SID_W-1:0]  sid_s1;
	logic [ENTRY_W-1:0] base_s1;
	logic [ENTRY_W-1:0] len_s1;

	// Result stage.
	logic                  valid_s2;
	logic                  acc_s2;
	kind_t                 kind_s2;
	logic [ADDR_WIDTH-1:0] addr_s2;
	logic [SIL_W-1:0]      sil_s2;
	logic [SID_W-1:0]      snd_s2;

	logic ready_s2;
	logic adv_s1;

	ring_stat_t            ring_stat;
	ring_ctl_t             ring_ctl;
	logic                  tbl_wr_en;
	logic [ADDR_WIDTH-1:0] tbl_base;
	logic [ADDR_WIDTH-1:0] tbl_len;

	logic                  res_accepted;
	kind_t                 res_kind;
	logic [ADDR_WIDTH-1:0] res_addr;
	logic [SIL_W-1:0]      res_silence;
	logic [SID_W-1:0]      res_sound;

	// The result register frees up when it is empty or being drained; the
	// input stage moves forward whenever the result register can take it.
	assign ready_s2 = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && ready_s2;
	assign s_tready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silence_q <= '0;
		end else if (cfg_wr_en) begin
			silence_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tuser;
			sid_s1  <= s_tdata[SID_W-1:0];
			base_s1 <= s_tdata[SID_W + ENTRY_W-1:SID_W];
			len_s1  <= s_tdata[SID_W + 2 * ENTRY_W-1:SID_W + ENTRY_W];
		end
	end

	srq_ring #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ring_ctl),
		.push_sound(sid_s1),
		.stat      (ring_stat)
	);

	srq_table #(
		.SOUND_COUNT(SOUND_COUNT),
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_table (
		.clk     (clk),
		.wr_en   (tbl_wr_en),
		.wr_sound(sid_s1),
		.wr_base (ADDR_WIDTH'(base_s1)),
		.wr_len  (ADDR_WIDTH'(len_s1)),
		.rd_sound(ring_stat.head_sound),
		.rd_base (tbl_base),
		.rd_len  (tbl_len)
	);

	srq_player #(
		.SOUND_COUNT(SOUND_COUNT),
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_player (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (adv_s1),
		.op          (op_s1),
		.sound_num   (sid_s1),
		.silence     (silence_q),
		.ring_stat   (ring_stat),
		.tbl_base    (tbl_base),
		.tbl_len     (tbl_len),
		.ring_ctl    (ring_ctl),
		.tbl_wr_en   (tbl_wr_en),
		.res_accepted(res_accepted),
		.res_kind    (res_kind),
		.res_addr    (res_addr),
		.res_silence (res_silence),
		.res_sound   (res_sound)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= adv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			acc_s2  <= res_accepted;
			kind_s2 <= res_kind;
			addr_s2 <= res_addr;
			sil_s2  <= res_silence;
			snd_s2  <= res_sound;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = kind_s2;
	assign m_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, snd_s2, sil_s2, addr_s2, acc_s2};

`ifndef SYNTHESIS
	// A word waiting in the input stage stays put while the result is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(op_s1) && $stable(sid_s1)))
		else $error("input stage word changed while stalled");

	// The ring is never pushed and popped by the same word.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(ring_ctl.push && ring_ctl.pop))
		else $error("ring push and pop in one cycle");

	// A push never lands on a full ring.
	assert property (@(posedge clk) disable iff (!arst_n)
		ring_ctl.push |-> !ring_stat.full)
		else $error("push into full ring");

	// A pop never happens on an empty ring.
	assert property (@(posedge clk) disable iff (!arst_n)
		ring_ctl.pop |-> !ring_stat.empty)
		else $error("pop from empty ring");

	// Every sample or silence result belongs to an accepted fetch.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (kind_s2 == KIND_SAMPLE || kind_s2 == KIND_SILENCE)) |-> acc_s2)
		else $error("byte result without acceptance");
`endif

endmodule

// File: sim/sound_request_queue_player_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sound_request_queue_player_test: self-checking bench for the request player
// Drives play, fetch, load and unused words into the block, predicts every
// result word from a behavioral copy of the queue, table and player, and
// compares each returned word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sound_request_queue_player_test import srq_pkg::*; ();

	localparam int QDEPTH  = DEF_QUEUE_DEPTH;
	localparam int NSOUNDS = DEF_SOUND_COUNT;
	localparam int AW      = DEF_ADDR_WIDTH;
	localparam int SDATA_W = ((SID_W + 2 * ENTRY_W + 7) / 8) * 8;
	localparam int MDATA_W = ((1 + AW + SIL_W + SID_W + 7) / 8) * 8;

	// The fourth operation code has no meaning; the block must answer it with an
	// all-zero word.
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	// One result word, unpacked into its fields.
	typedef struct packed {
		logic              accepted;
		kind_t             kind;
		logic [AW-1:0]     addr;
		logic [SIL_W-1:0]  sil;
		logic [SID_W-1:0]  snd;
	} player_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [SIL_W-1:0]    cfg_wr_data = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [SDATA_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]     s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [MDATA_W-1:0]  m_tdata;
	logic [KIND_W-1:0]   m_tuser;

	// Bench-side copy of the block's state. The ring indexes are plain integers
	// so the wrap is an explicit modulo.
	logic [SID_W-1:0]    ring_copy [QDEPTH];
	int                  ring_rd;
	int                  ring_wr;
	bit                  now_playing;
	logic [SID_W-1:0]    cur_sound;
	logic [AW-1:0]       cur_base;
	logic [AW-1:0]       cur_len;
	logic [AW-1:0]       cur_pos;
	logic [AW-1:0]       base_copy [NSOUNDS];
	logic [AW-1:0]       len_copy [NSOUNDS];
	logic [SIL_W-1:0]    silence_copy;

	// Table entries that have been written at least once. Play requests are only
	// ever made for these, so the block never reads an unwritten entry.
	bit                  table_loaded [NSOUNDS];

	player_result_t      awaited_results [$];
	int                  fail_count = 0;

	// Idling controls shared between the test tasks and the two stream sides.
	bit                  src_idle_on = 1'b0;
	bit                  sink_idle_on = 1'b0;
	int                  hold_req = 0;
	int                  hold_left = 0;

	sound_request_queue_player #(
		.QUEUE_DEPTH(QDEPTH),
		.SOUND_COUNT(NSOUNDS),
		.ADDR_WIDTH(AW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		// s_tdata: sound number, entry_base, entry_length, zero fill.
		.s_tdata(s_tdata),
		// s_tuser: op.
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		// m_tdata: accepted, sample_address, silence_byte, playing_sound, zero fill.
		.m_tdata(m_tdata),
		// m_tuser: output_kind.
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Computes the result word for one accepted input word and advances the
	// bench copy of the queue, table and player.
	function automatic player_result_t next_player_result(
		input logic [OP_W-1:0]   op,
		input logic [SID_W-1:0]  sid,
		input logic [AW-1:0]     base,
		input logic [AW-1:0]     len
	);
		player_result_t r;
		int             nxt;
		logic [SID_W-1:0] s;
		r = '0;
		case (op)
			OP_PLAY: begin
				// One slot always stays free, so the ring refuses when the write
				// index would catch up with the read index.
				nxt = (ring_wr + 1) % QDEPTH;
				if (sid < NSOUNDS && nxt != ring_rd) begin
					ring_copy[ring_wr] = sid;
					ring_wr = nxt;
					r.accepted = 1'b1;
				end
			end
			OP_FETCH: begin
				r.accepted = 1'b1;
				if (!now_playing && ring_rd != ring_wr) begin
					s = ring_copy[ring_rd];
					ring_rd = (ring_rd + 1) % QDEPTH;
					cur_sound = s;
					cur_base = base_copy[s];
					cur_len = len_copy[s];
					cur_pos = '0;
					now_playing = 1'b1;
				end
				if (now_playing) begin
					r.kind = KIND_SAMPLE;
					r.addr = cur_base + cur_pos;
					r.snd = cur_sound;
					cur_pos = cur_pos + 1'b1;
					// A zero length still plays one byte, since the position is
					// compared only after it has advanced.
					if (cur_pos >= cur_len || cur_pos == '0) begin
						now_playing = 1'b0;
						cur_len = '0;
						cur_base = '0;
						cur_pos = '0;
					end
				end else begin
					r.kind = KIND_SILENCE;
					r.sil = silence_copy;
				end
			end
			OP_LOAD: begin
				if (sid < NSOUNDS) begin
					base_copy[sid] = base;
					len_copy[sid] = len;
					r.accepted = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Offers one word and holds it until the block takes it. Entered and left
	// at a falling edge; tvalid stays high on return so back-to-back words need
	// no extra assignment.
	task automatic send_word(
		input logic [OP_W-1:0]   op,
		input logic [SID_W-1:0]  sid,
		input logic [AW-1:0]     base,
		input logic [AW-1:0]     len
	);
		int gap;
		gap = 0;
		if (src_idle_on) begin
			while ($urandom_range(99) < 25)
				gap++;
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(SDATA_W - SID_W - 2 * ENTRY_W){1'b0}}, len, base, sid};
		do
			@(posedge clk);
		while (!s_tready);
		awaited_results.push_back(next_player_result(op, sid, base, len));
		if (op == OP_LOAD)
			table_loaded[sid] = 1'b1;
		@(negedge clk);
	endtask

	// Lowers tvalid and waits until every predicted word has come back, then
	// lets the two-stage pipeline settle.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Writes the silence byte while the block is idle.
	task automatic set_silence(input logic [SIL_W-1:0] value);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		silence_copy = value;
		@(negedge clk);
	endtask

	function automatic logic [OP_W-1:0] pick_op(input int play_pct, input int fetch_pct,
			input int load_pct);
		int r;
		r = $urandom_range(99);
		if (r < play_pct)
			return OP_PLAY;
		else if (r < play_pct + fetch_pct)
			return OP_FETCH;
		else if (r < play_pct + fetch_pct + load_pct)
			return OP_LOAD;
		return OP_SPARE;
	endfunction

	// Mostly short sounds so the queue keeps moving, with a few longer ones.
	function automatic logic [AW-1:0] pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 85)
			return AW'($urandom_range(6, 0));
		else if (r < 98)
			return AW'($urandom_range(40, 7));
		return AW'($urandom_range(200, 41));
	endfunction

	// Sends one random word; play requests only name loaded sounds.
	task automatic send_random_word(input int play_pct, input int fetch_pct,
			input int load_pct);
		logic [OP_W-1:0]  op;
		logic [SID_W-1:0] sid;
		logic [AW-1:0]    base;
		logic [AW-1:0]    len;
		op = pick_op(play_pct, fetch_pct, load_pct);
		sid = SID_W'($urandom);
		base = AW'($urandom);
		len = AW'($urandom);
		if (op == OP_PLAY) begin
			while (!table_loaded[sid])
				sid = SID_W'($urandom_range(NSOUNDS - 1));
		end else if (op == OP_LOAD) begin
			len = pick_length();
		end
		send_word(op, sid, base, len);
	endtask

	// Right after reset: the queue is empty, so a fetch gives the reset silence
	// value, and the unused operation changes nothing.
	task automatic test_reset_state();
		send_word(OP_FETCH, 4'h0, '0, '0);
		send_word(OP_SPARE, 4'hF, {AW{1'b1}}, {AW{1'b1}});
		send_word(OP_FETCH, 4'h3, '0, '0);
		drain_results();
	endtask

	// Table loads at the field extremes, then a short play list covering a
	// zero-length sound and a sample range that wraps past the top address.
	task automatic test_table_and_playback();
		send_word(OP_LOAD, 4'hF, {AW{1'b1}}, {AW{1'b1}});
		send_word(OP_LOAD, 4'h0, '0, '0);
		// Reloading the maximum-length entry keeps playback bounded.
		send_word(OP_LOAD, 4'hF, 24'hFFFFFD, 24'd5);
		send_word(OP_LOAD, 4'h5, 24'h123456, 24'd2);
		send_word(OP_PLAY, 4'h0, '0, '0);
		send_word(OP_PLAY, 4'hF, '0, '0);
		send_word(OP_PLAY, 4'h5, '0, '0);
		// One byte of the zero-length sound, five wrapping bytes, two more, then
		// silence once the queue has run dry.
		repeat (9) send_word(OP_FETCH, 4'h0, '0, '0);
		drain_results();
	endtask

	// Fills the ring: the request that would use the last free slot is refused.
	// The queued requests are left for the random traffic to play out.
	task automatic test_full_queue();
		repeat (QDEPTH) send_word(OP_PLAY, 4'h0, '0, '0);
		drain_results();
	endtask

	task automatic test_random_traffic(input int words, input int play_pct,
			input int fetch_pct, input int load_pct);
		repeat (words) send_random_word(play_pct, fetch_pct, load_pct);
		drain_results();
	endtask

	// The receiver stops taking results for a long stretch while words keep
	// arriving, so both internal stages fill and the input stalls.
	task automatic test_output_stall();
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		hold_req = 300;
		repeat (40) send_random_word(35, 55, 7);
		drain_results();
	endtask

	// Result side: ready pattern is set at the falling edge, one assignment per
	// edge. A hold request takes priority over random idling.
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (sink_idle_on) begin
			m_tready <= ($urandom_range(99) >= 25);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Result checker: every word the block hands over is matched against the
	// oldest prediction, field by field.
	always @(posedge clk) begin
		player_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_results.size() == 0) begin
				$error("result word with no prediction waiting: tdata %h tuser %h",
					m_tdata, m_tuser);
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				if (m_tdata[0] !== want.accepted) begin
					$error("accepted: expected %0d, got %0d", want.accepted, m_tdata[0]);
					fail_count++;
				end
				if (m_tuser !== want.kind) begin
					$error("output_kind: expected %0d, got %0d", want.kind, m_tuser);
					fail_count++;
				end
				if (m_tdata[AW:1] !== want.addr) begin
					$error("sample_address: expected %h, got %h", want.addr, m_tdata[AW:1]);
					fail_count++;
				end
				if (m_tdata[AW+SIL_W:AW+1] !== want.sil) begin
					$error("silence_byte: expected %h, got %h", want.sil,
						m_tdata[AW+SIL_W:AW+1]);
					fail_count++;
				end
				if (m_tdata[AW+SIL_W+SID_W:AW+SIL_W+1] !== want.snd) begin
					$error("playing_sound: expected %0d, got %0d", want.snd,
						m_tdata[AW+SIL_W+SID_W:AW+SIL_W+1]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		ring_rd = 0;
		ring_wr = 0;
		now_playing = 1'b0;
		cur_sound = '0;
		cur_base = '0;
		cur_len = '0;
		cur_pos = '0;
		silence_copy = '0;
		foreach (table_loaded[i])
			table_loaded[i] = 1'b0;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		set_silence(8'hFF);
		test_table_and_playback();
		test_full_queue();

		// Random traffic with both sides idling now and then.
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		set_silence(8'h00);
		test_random_traffic(400, 30, 55, 10);

		// A long stretch with no idling on either side, biased toward play
		// requests so the ring stays near full and refusals are common.
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		set_silence(8'hA5);
		test_random_traffic(400, 50, 40, 7);

		test_output_stall();

		// Fetch-heavy traffic: the queue empties often and silence is common.
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		set_silence(SIL_W'($urandom));
		test_random_traffic(500, 20, 70, 7);

		set_silence(8'h5A);
		test_random_traffic(460, 33, 52, 10);

		if (fail_count == 0)
			$display("sound_request_queue_player regression: pass");
		else
			$display("sound_request_queue_player regression: fail");
		$finish;
	end

	// Generous overall limit; a correct run needs a small fraction of it.
	initial begin
		#2000000;
		$display("sound_request_queue_player regression: fail");
		$finish;
	end

endmodule
